### rtl/core/bsp_pkg.sv
// bsp_pkg: shared types and character constants for the bencode scalar parser
// used by bsp_front, bsp_queue, bsp_back and bencode_scalar_parser
// no dependencies
package bsp_pkg;

    // stream characters
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_L     = 8'h6c;  // 'l'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // byte class as decided by the front
    typedef enum logic [2:0] {
        CLS_END,
        CLS_DIGIT,
        CLS_INT,
        CLS_E,
        CLS_COLON,
        CLS_MINUS,
        CLS_CONT,
        CLS_OTHER
    } t_class;

    // classified byte carried from front to back
    typedef struct packed {
        t_class     cls;
        logic [7:0] byte_val;
        logic [3:0] digit;
    } t_token;

    // parse phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_INT,
        PH_LEN,
        PH_DATA
    } t_phase;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_LEN  = 3'd1,
        EV_BYTE = 3'd2,
        EV_INT  = 3'd3,
        EV_OPEN = 3'd4,
        EV_ERR  = 3'd5
    } t_event;

    // error codes
    typedef enum logic [2:0] {
        ERR_TYPE  = 3'd0,
        ERR_DIGIT = 3'd1,
        ERR_COLON = 3'd2,
        ERR_E     = 3'd3,
        ERR_NEG   = 3'd4,
        ERR_OVF   = 3'd5,
        ERR_TRUNC = 3'd6
    } t_err;

endpackage

### rtl/core/bsp_front.sv
// bsp_front: input side of the parser, accepts stream bytes and classifies them
// depends on bsp_pkg
module bsp_front (
    input  logic            i_valid,
    input  logic [7:0]      i_byte_in,
    input  logic            i_stream_end,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output bsp_pkg::t_token o_token
);
    import bsp_pkg::*;

    logic w_is_digit;

    // input transfer whenever the queue has room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign w_is_digit = (i_byte_in >= CH_ZERO) && (i_byte_in <= CH_NINE);

    // byte classification, stream end wins over the byte
    always_comb begin
        o_token.byte_val = i_byte_in;
        o_token.digit    = i_byte_in[3:0];
        priority if (i_stream_end) begin
            o_token.cls = CLS_END;
        end else if (w_is_digit) begin
            o_token.cls = CLS_DIGIT;
        end else if (i_byte_in == CH_I) begin
            o_token.cls = CLS_INT;
        end else if (i_byte_in == CH_E) begin
            o_token.cls = CLS_E;
        end else if (i_byte_in == CH_COLON) begin
            o_token.cls = CLS_COLON;
        end else if (i_byte_in == CH_MINUS) begin
            o_token.cls = CLS_MINUS;
        end else if (i_byte_in == CH_D || i_byte_in == CH_L) begin
            o_token.cls = CLS_CONT;
        end else begin
            o_token.cls = CLS_OTHER;
        end
    end

endmodule

### rtl/core/bsp_queue.sv
// bsp_queue: small register queue of classified bytes between front and back
// depends on bsp_pkg; DEPTH must be 2 or more
module bsp_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsp_pkg::t_token i_token,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output bsp_pkg::t_token o_token
);
    import bsp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_token          r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd];

    // pointer wrap
    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

### rtl/core/bsp_back.sv
// bsp_back: parse state machine and result register of the parser
// depends on bsp_pkg; takes classified bytes from bsp_queue
module bsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  bsp_pkg::t_token i_token,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [2:0]      o_event_res,
    output logic [63:0]     o_value,
    output logic [7:0]      o_data_byte,
    output logic            o_is_negative,
    output logic            o_last,
    output logic [2:0]      o_error_code
);
    import bsp_pkg::*;

    // parse state
    t_phase       r_phase;
    t_phase       n_phase;
    logic [63:0]  r_acc;
    logic [63:0]  n_acc;
    logic         r_neg;
    logic         n_neg;
    logic         r_dig;
    logic         n_dig;
    logic [63:0]  r_left;
    logic [63:0]  n_left;

    // result register
    logic         r_out_valid;
    t_event       r_out_event;
    logic [63:0]  r_out_value;
    logic [7:0]   r_out_byte;
    logic         r_out_neg;
    logic         r_out_last;
    t_err         r_out_err;
    t_event       n_out_event;
    logic [63:0]  n_out_value;
    logic [7:0]   n_out_byte;
    logic         n_out_neg;
    logic         n_out_last;
    t_err         n_out_err;

    // arithmetic
    logic [67:0]  w_sum;
    logic         w_ovf;
    logic         w_neg_big;
    logic [63:0]  w_neg_val;
    logic [63:0]  w_left_dec;
    logic         w_left_one;
    logic         w_acc_zero;

    // take a byte when the result register is free or being drained
    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    // acc * 10 + digit, overflow when anything lands above bit 63
    assign w_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {64'd0, i_token.digit};
    assign w_ovf      = |w_sum[67:64];
    assign w_neg_big  = r_acc[63] && (|r_acc[62:0]);
    assign w_neg_val  = 64'd0 - r_acc;
    assign w_left_dec = r_left - 64'd1;
    assign w_left_one = (r_left == 64'd1);
    assign w_acc_zero = (r_acc == 64'd0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_token.cls == CLS_END) begin
            n_phase = PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_token.cls == CLS_INT) begin
                        n_phase = PH_INT;
                    end else if (i_token.cls == CLS_DIGIT) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_INT: begin
                    priority if (i_token.cls == CLS_DIGIT) begin
                        n_phase = w_ovf ? PH_IDLE : PH_INT;
                    end else if (!r_dig) begin
                        n_phase = (i_token.cls == CLS_MINUS && !r_neg) ? PH_INT : PH_IDLE;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    priority if (i_token.cls == CLS_DIGIT) begin
                        n_phase = w_ovf ? PH_IDLE : PH_LEN;
                    end else if (i_token.cls == CLS_COLON) begin
                        n_phase = w_acc_zero ? PH_IDLE : PH_DATA;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    n_phase = w_left_one ? PH_IDLE : PH_DATA;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // datapath and result values
    always_comb begin
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_dig       = r_dig;
        n_left      = r_left;
        n_out_event = EV_NONE;
        n_out_value = 64'd0;
        n_out_byte  = 8'd0;
        n_out_neg   = 1'b0;
        n_out_last  = 1'b0;
        n_out_err   = ERR_TYPE;
        if (i_token.cls == CLS_END) begin
            if (r_phase != PH_IDLE) begin
                n_out_event = EV_ERR;
                n_out_err   = ERR_TRUNC;
                n_acc       = 64'd0;
                n_neg       = 1'b0;
                n_dig       = 1'b0;
                n_left      = 64'd0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_token.cls == CLS_DIGIT) begin
                        n_acc = {60'd0, i_token.digit};
                        n_dig = 1'b1;
                    end else if (i_token.cls == CLS_CONT) begin
                        n_out_event = EV_OPEN;
                        n_out_byte  = i_token.byte_val;
                    end else if (i_token.cls != CLS_INT) begin
                        n_out_event = EV_ERR;
                        n_out_err   = ERR_TYPE;
                        n_out_byte  = i_token.byte_val;
                    end
                end
                PH_INT: begin
                    priority if (i_token.cls == CLS_DIGIT) begin
                        if (w_ovf) begin
                            n_out_event = EV_ERR;
                            n_out_err   = ERR_OVF;
                            n_out_byte  = i_token.byte_val;
                        end else begin
                            n_acc = w_sum[63:0];
                            n_dig = 1'b1;
                        end
                    end else if (!r_dig) begin
                        if (i_token.cls == CLS_MINUS && !r_neg) begin
                            n_neg = 1'b1;
                        end else begin
                            n_out_event = EV_ERR;
                            n_out_err   = ERR_DIGIT;
                            n_out_byte  = i_token.byte_val;
                        end
                    end else if (i_token.cls == CLS_E) begin
                        if (r_neg && w_neg_big) begin
                            n_out_event = EV_ERR;
                            n_out_err   = ERR_NEG;
                            n_out_byte  = i_token.byte_val;
                        end else begin
                            n_out_event = EV_INT;
                            n_out_value = r_neg ? w_neg_val : r_acc;
                            n_out_neg   = r_neg;
                        end
                    end else begin
                        n_out_event = EV_ERR;
                        n_out_err   = ERR_E;
                        n_out_byte  = i_token.byte_val;
                    end
                    // any result ends the integer
                    if (n_out_event != EV_NONE) begin
                        n_acc = 64'd0;
                        n_neg = 1'b0;
                        n_dig = 1'b0;
                    end
                end
                PH_LEN: begin
                    priority if (i_token.cls == CLS_DIGIT) begin
                        if (w_ovf) begin
                            n_out_event = EV_ERR;
                            n_out_err   = ERR_OVF;
                            n_out_byte  = i_token.byte_val;
                            n_acc       = 64'd0;
                            n_dig       = 1'b0;
                        end else begin
                            n_acc = w_sum[63:0];
                            n_dig = 1'b1;
                        end
                    end else if (i_token.cls == CLS_COLON) begin
                        n_out_event = EV_LEN;
                        n_out_value = r_acc;
                        n_out_last  = w_acc_zero;
                        n_left      = r_acc;
                        n_acc       = 64'd0;
                        n_dig       = 1'b0;
                    end else begin
                        n_out_event = EV_ERR;
                        n_out_err   = ERR_COLON;
                        n_out_byte  = i_token.byte_val;
                        n_acc       = 64'd0;
                        n_dig       = 1'b0;
                    end
                end
                PH_DATA: begin
                    n_left      = w_left_dec;
                    n_out_event = EV_BYTE;
                    n_out_byte  = i_token.byte_val;
                    n_out_last  = w_left_one;
                end
                default: begin
                    n_acc  = 64'd0;
                    n_neg  = 1'b0;
                    n_dig  = 1'b0;
                    n_left = 64'd0;
                end
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= 64'd0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
            r_left  <= 64'd0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_dig   <= n_dig;
            r_left  <= n_left;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_event <= n_out_event;
            r_out_value <= n_out_value;
            r_out_byte  <= n_out_byte;
            r_out_neg   <= n_out_neg;
            r_out_last  <= n_out_last;
            r_out_err   <= n_out_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out_event;
    assign o_value       = r_out_value;
    assign o_data_byte   = r_out_byte;
    assign o_is_negative = r_out_neg;
    assign o_last        = r_out_last;
    assign o_error_code  = r_out_err;

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != 64'd0)
        else $error("payload phase with no bytes left");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_acc == 64'd0 && !r_neg && !r_dig))
        else $error("idle phase with stale value state");

    a_err_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_out_event == EV_ERR) |=> r_phase == PH_IDLE)
        else $error("error did not return parser to idle");

endmodule

### rtl/core/bencode_scalar_parser.sv
// bencode_scalar_parser: top level of the bencode scalar decoder
// depends on bsp_pkg, bsp_front, bsp_queue and bsp_back
//
// Usage:
//   input channel  i_valid / o_stall carries one stream byte (i_byte_in) or an
//   end-of-stream mark (i_stream_end); a transfer happens at a clock edge with
//   i_valid high and o_stall low
//   output channel o_valid / i_stall carries exactly one result per input
//   transfer: event code, value, data byte, sign, last mark and error code
//   throughput: one byte per clock, sustained as long as results are taken
//   each input byte is first written into the queue and then loaded from the
//   queue into the result register, from which its result is presented
//   the queue (QUEUE_DEPTH entries) sits between the classifier and the
//   state machine; o_stall rises only when the queue is full
//   while the receiver holds i_stall, the result register holds its value
//   and input keeps flowing until the queue fills
//   i_rst_n (synchronous, active low) empties the queue, drops o_valid and
//   puts the parser in idle, awaiting a type byte
//   errors are reported as one result and the parser returns to idle
module bencode_scalar_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [63:0] o_value,
    output logic [7:0]  o_data_byte,
    output logic        o_is_negative,
    output logic        o_last,
    output logic [2:0]  o_error_code
);
    import bsp_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_q_full;
    logic   w_q_valid;
    t_token w_in_token;
    t_token w_q_token;

    // classifier
    bsp_front u_front (
        .i_valid      (i_valid),
        .i_byte_in    (i_byte_in),
        .i_stream_end (i_stream_end),
        .i_q_full     (w_q_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_token      (w_in_token)
    );

    // decoupling queue
    bsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_in_token),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_token (w_q_token)
    );

    // parse state machine and result register
    bsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_token       (w_q_token),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_event_res   (o_event_res),
        .o_value       (o_value),
        .o_data_byte   (o_data_byte),
        .o_is_negative (o_is_negative),
        .o_last        (o_last),
        .o_error_code  (o_error_code)
    );

endmodule
